// ----- sv/svdc_pkg.sv -----
// Shared types, constants and helper functions for the sweep/dihedral converter.
// Holds the CORDIC arctangent table, fixed-point formats and snap targets.
// No dependencies.
package svdc_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int ANG_FRAC         = 24;
  localparam int GUARD            = 4;
  localparam int TAB_LEN          = 30;
  localparam int CORDIC_STEPS_DEF = 20;

  // internal coordinate, internal angle, port-unit angle and product widths
  localparam int CW = 39;
  localparam int ZW = 34;
  localparam int AW = 27;
  localparam int PW = CW + 27;

  localparam logic signed [26:0] GAIN_S = 27'sd40752055;
  localparam logic        [25:0] GAIN_U = 26'd40752055;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(longint'(90) << ANG_FRAC);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(longint'(180) << ANG_FRAC);

  localparam int Q90  = 90 << FRAC_BITS;
  localparam int Q180 = 180 << FRAC_BITS;
  localparam int Q270 = 270 << FRAC_BITS;
  localparam int Q360 = 360 << FRAC_BITS;

  localparam logic signed [AW-1:0] FULL_Q = AW'(Q360);
  localparam logic signed [AW-1:0] HALF_Q = AW'(Q180);
  localparam logic signed [AW-1:0] QTR_Q  = AW'(Q90);

  localparam logic signed [AW-1:0] SNAP_AT [9] = '{
    AW'(0), AW'(Q90), AW'(Q180), AW'(Q270), AW'(Q360),
    AW'(-Q90), AW'(-Q180), AW'(-Q270), AW'(-Q360)
  };
  localparam logic signed [AW-1:0] SNAP_TO [9] = '{
    AW'(0), AW'(Q90), AW'(Q180), AW'(Q270), AW'(0),
    AW'(-Q90), AW'(-Q180), AW'(-Q270), AW'(0)
  };

  typedef enum logic {
    REQ_FWD = 1'b0,
    REQ_INV = 1'b1
  } req_t;

  // sideband carried alongside the first CORDIC pass
  typedef struct packed {
    logic                 fs;
    logic                 fd;
    logic signed [ZW-1:0] d_ang;
    logic                 y_neg;
    logic                 zero_a;
    logic signed [ZW-1:0] off_a;
    logic signed [31:0]   x_in;
    logic                 nz;
  } sba_t;

  // sideband carried alongside the second CORDIC pass
  typedef struct packed {
    logic signed [CW-1:0] sy;
    logic                 fd;
    logic signed [ZW-1:0] ang_a;
    logic                 zero_b;
    logic signed [ZW-1:0] off_b;
    logic                 nz;
  } sbb_t;

  // round(atan(2^-i) * 180/pi * 2^24)
  function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 34'sd754974720;
      1:  v = 34'sd445687602;
      2:  v = 34'sd235489088;
      3:  v = 34'sd119537938;
      4:  v = 34'sd60000934;
      5:  v = 34'sd30029717;
      6:  v = 34'sd15018523;
      7:  v = 34'sd7509720;
      8:  v = 34'sd3754917;
      9:  v = 34'sd1877466;
      10: v = 34'sd938734;
      11: v = 34'sd469367;
      12: v = 34'sd234684;
      13: v = 34'sd117342;
      14: v = 34'sd58671;
      15: v = 34'sd29335;
      16: v = 34'sd14668;
      17: v = 34'sd7334;
      18: v = 34'sd3667;
      19: v = 34'sd1833;
      20: v = 34'sd917;
      21: v = 34'sd458;
      22: v = 34'sd229;
      23: v = 34'sd115;
      24: v = 34'sd57;
      25: v = 34'sd29;
      26: v = 34'sd14;
      27: v = 34'sd7;
      28: v = 34'sd4;
      29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // remainder by 360 (truncating), then into (-180, 180]
  function automatic logic signed [AW-1:0] reduce_q(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    r = a;
    if (r >= FULL_Q) begin
      r = r - FULL_Q;
    end else if (r <= -FULL_Q) begin
      r = r + FULL_Q;
    end
    if (r > HALF_Q) begin
      r = r - FULL_Q;
    end else if (r <= -HALF_Q) begin
      r = r + FULL_Q;
    end
    return r;
  endfunction

  function automatic logic signed [AW-1:0] rshr8(input logic signed [ZW-1:0] v);
    logic signed [ZW:0] t;
    t = (ZW+1)'(v) + (ZW+1)'(128);
    return AW'(t >>> (ANG_FRAC - FRAC_BITS));
  endfunction

  // apply snap targets first..last in order; a replaced value is tested again
  function automatic logic signed [AW-1:0] snap_run(input logic signed [AW-1:0] v,
                                                     input logic [15:0] tol,
                                                     input int first, input int last);
    logic signed [AW-1:0] r;
    logic signed [AW+1:0] d;
    logic signed [AW+1:0] tl;
    r  = v;
    tl = (AW+2)'(tol);
    for (int k = 0; k < 9; k++) begin
      d = (AW+2)'(r) - (AW+2)'(SNAP_AT[k]);
      if (k >= first && k <= last && d >= -tl && d <= tl) begin
        r = SNAP_TO[k];
      end
    end
    return r;
  endfunction

  function automatic logic signed [25:0] sat26(input logic signed [AW-1:0] v);
    logic signed [25:0] r;
    if (v > AW'(33554431)) begin
      r = 26'sd33554431;
    end else if (v < AW'(-33554432)) begin
      r = -26'sd33554432;
    end else begin
      r = v[25:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [31:0]   r;
    t = (v + CW'(8)) >>> GUARD;
    if (t > CW'(64'sd2147483647)) begin
      r = 32'sh7FFFFFFF;
    end else if (t < CW'(-64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/svdc_cordic.sv -----
// Unrolled CORDIC pipeline, one register stage per micro-rotation.
// Each item picks rotation (drive angle to zero) or vectoring (drive y to zero).
// Depends on svdc_pkg.
module svdc_cordic #(
  parameter int unsigned STEPS = svdc_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned SB_W  = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_vec,
  input  logic signed [svdc_pkg::CW-1:0] in_x,
  input  logic signed [svdc_pkg::CW-1:0] in_y,
  input  logic signed [svdc_pkg::ZW-1:0] in_z,
  input  logic [SB_W-1:0]               in_sb,
  output logic                          out_valid,
  output logic                          out_vec,
  output logic signed [svdc_pkg::CW-1:0] out_x,
  output logic signed [svdc_pkg::CW-1:0] out_y,
  output logic signed [svdc_pkg::ZW-1:0] out_z,
  output logic [SB_W-1:0]               out_sb
);
  import svdc_pkg::*;

  logic                 v_r   [STEPS];
  logic                 vec_r [STEPS];
  logic signed [CW-1:0] x_r   [STEPS];
  logic signed [CW-1:0] y_r   [STEPS];
  logic signed [ZW-1:0] z_r   [STEPS];
  logic [SB_W-1:0]      sb_r  [STEPS];

  logic                 v_nxt   [STEPS];
  logic                 vec_nxt [STEPS];
  logic signed [CW-1:0] x_nxt   [STEPS];
  logic signed [CW-1:0] y_nxt   [STEPS];
  logic signed [ZW-1:0] z_nxt   [STEPS];
  logic [SB_W-1:0]      sb_nxt  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic                 vi, veci, neg;
    logic signed [CW-1:0] xi, yi;
    logic signed [ZW-1:0] zi, t;
    logic [SB_W-1:0]      sbi;

    if (i == 0) begin : g_first
      assign vi   = in_valid;
      assign veci = in_vec;
      assign xi   = in_x;
      assign yi   = in_y;
      assign zi   = in_z;
      assign sbi  = in_sb;
    end else begin : g_next
      assign vi   = v_r[i-1];
      assign veci = vec_r[i-1];
      assign xi   = x_r[i-1];
      assign yi   = y_r[i-1];
      assign zi   = z_r[i-1];
      assign sbi  = sb_r[i-1];
    end

    assign t   = atan_val(i);
    // rotate the other way when the residual angle is negative or y is above the axis
    assign neg = veci ? (yi > 0) : zi[ZW-1];

    assign v_nxt[i]   = vi;
    assign vec_nxt[i] = veci;
    assign sb_nxt[i]  = sbi;
    assign x_nxt[i]   = neg ? xi + (yi >>> i) : xi - (yi >>> i);
    assign y_nxt[i]   = neg ? yi - (xi >>> i) : yi + (xi >>> i);
    assign z_nxt[i]   = neg ? zi + t : zi - t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STEPS; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < STEPS; i++) v_r[i] <= v_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STEPS; i++) begin
        vec_r[i] <= vec_nxt[i];
        x_r[i]   <= x_nxt[i];
        y_r[i]   <= y_nxt[i];
        z_r[i]   <= z_nxt[i];
        sb_r[i]  <= sb_nxt[i];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_vec   = vec_r[STEPS-1];
  assign out_x     = x_r[STEPS-1];
  assign out_y     = y_r[STEPS-1];
  assign out_z     = z_r[STEPS-1];
  assign out_sb    = sb_r[STEPS-1];

endmodule

// ----- sv/sweep_dihedral_vector_converter.sv -----
// Converts between (length, sweep, dihedral) and (x, y, z), per item.
// Top level: front-end stages, two CORDIC pipelines, back-end and output register.
// Depends on svdc_pkg and svdc_cordic.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transfer; in_req_type
//   selects forward (angles to vector) or inverse (vector to angles). Fields not used
//   by the selected direction are ignored; result fields of the other direction are 0.
//   Result channel (out_valid/out_ready) returns one result per request, in order.
//   cfg_snap_tolerance is written through cfg_valid/cfg_ready (always ready); write
//   it only while no request is in flight.
// Throughput: one item per cycle while the output is not stalled, set by the fully
//   unrolled CORDIC stages; each pass has one register per micro-rotation.
// Reset: rst_n low synchronously empties the pipeline and loads the snap tolerance
//   with 66 (about 0.001 degree).
// Stall: while out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready drops in the same cycle; nothing is dropped or repeated.
module sweep_dihedral_vector_converter #(
  parameter int unsigned CORDIC_STEPS = svdc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  input  logic signed [31:0] in_z_coord,
  input  logic [30:0]        in_length_in,
  input  logic signed [25:0] in_sweep_in,
  input  logic signed [25:0] in_dihedral_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic signed [31:0] out_z_out,
  output logic [31:0]        out_length_out,
  output logic signed [25:0] out_sweep_out,
  output logic signed [25:0] out_dihedral_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_snap_tolerance
);
  import svdc_pkg::*;

  logic en;
  logic [15:0] tol_r;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd66;
    end else if (cfg_valid) begin
      tol_r <= cfg_snap_tolerance;
    end
  end

  // ---------------- stage 1: angle reduction, vector prep ----------------
  logic                 v1_r, t1_r, yneg1_r, zero1_r, nz1_r;
  logic [30:0]          len1_r;
  logic signed [AW-1:0] s1_r, d1_r;
  logic signed [CW-1:0] a1_r, b1_r;
  logic signed [ZW-1:0] off1_r;
  logic signed [31:0]   x1_r;

  logic signed [CW-1:0] a1_nxt, b1_nxt, ya, za;
  logic signed [ZW-1:0] off1_nxt;
  logic                 yneg1_nxt;

  always_comb begin
    ya        = CW'(in_y_coord) <<< GUARD;
    za        = CW'(in_z_coord) <<< GUARD;
    yneg1_nxt = in_y_coord[31];
    if (yneg1_nxt) begin
      a1_nxt   = -ya;
      b1_nxt   = -za;
      off1_nxt = in_z_coord[31] ? -DEG180 : DEG180;
    end else begin
      a1_nxt   = ya;
      b1_nxt   = za;
      off1_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r    <= in_req_type;
      len1_r  <= in_length_in;
      s1_r    <= reduce_q(AW'(in_sweep_in));
      d1_r    <= reduce_q(AW'(in_dihedral_in));
      a1_r    <= a1_nxt;
      b1_r    <= b1_nxt;
      off1_r  <= off1_nxt;
      yneg1_r <= yneg1_nxt;
      zero1_r <= (in_y_coord == '0) && (in_z_coord == '0);
      x1_r    <= in_x_coord;
      nz1_r   <= (in_x_coord != '0) || (in_y_coord != '0) || (in_z_coord != '0);
    end
  end

  // ---------------- stage 2: fold to +-90, gain-corrected length ----------------
  logic                 v2_r, t2_r;
  logic signed [CW-1:0] x2_r, y2_r;
  logic signed [ZW-1:0] z2_r;
  sba_t                 sba2_r;

  logic signed [AW-1:0] sf, df;
  logic                 fs, fd;
  logic [57:0]          lp;
  logic signed [CW-1:0] cx;

  always_comb begin
    fs = 1'b0;
    sf = s1_r;
    if (s1_r > QTR_Q) begin
      sf = s1_r - HALF_Q;
      fs = 1'b1;
    end else if (s1_r < -QTR_Q) begin
      sf = s1_r + HALF_Q;
      fs = 1'b1;
    end
    fd = 1'b0;
    df = d1_r;
    if (d1_r > QTR_Q) begin
      df = d1_r - HALF_Q;
      fd = 1'b1;
    end else if (d1_r < -QTR_Q) begin
      df = d1_r + HALF_Q;
      fd = 1'b1;
    end
    lp = 58'(len1_r) * 58'(GAIN_U) + (58'(1) << 21);
    cx = CW'(lp >> 22);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r          <= t1_r;
      x2_r          <= (t1_r == REQ_INV) ? a1_r : cx;
      y2_r          <= (t1_r == REQ_INV) ? b1_r : '0;
      z2_r          <= (t1_r == REQ_INV) ? '0 : (ZW'(sf) <<< (ANG_FRAC - FRAC_BITS));
      sba2_r.fs     <= fs;
      sba2_r.fd     <= fd;
      sba2_r.d_ang  <= ZW'(df) <<< (ANG_FRAC - FRAC_BITS);
      sba2_r.y_neg  <= yneg1_r;
      sba2_r.zero_a <= zero1_r;
      sba2_r.off_a  <= off1_r;
      sba2_r.x_in   <= x1_r;
      sba2_r.nz     <= nz1_r;
    end
  end

  // ---------------- first CORDIC pass ----------------
  logic                 va, veca;
  logic signed [CW-1:0] xa, yav;
  logic signed [ZW-1:0] zav;
  logic [$bits(sba_t)-1:0] sba_bits;
  sba_t                 sa;

  svdc_cordic #(.STEPS(CORDIC_STEPS), .SB_W($bits(sba_t))) u_cordic_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v2_r),
    .in_vec   (t2_r),
    .in_x     (x2_r),
    .in_y     (y2_r),
    .in_z     (z2_r),
    .in_sb    (sba2_r),
    .out_valid(va),
    .out_vec  (veca),
    .out_x    (xa),
    .out_y    (yav),
    .out_z    (zav),
    .out_sb   (sba_bits)
  );

  assign sa = sba_t'(sba_bits);

  // ---------------- stage 3: unfold, gain multiply ----------------
  logic                 v3_r, t3_r;
  logic signed [PW-1:0] p3_r;
  logic signed [CW-1:0] sy3_r;
  logic signed [ZW-1:0] ang3_r;
  sba_t                 sa3_r;
  logic signed [CW-1:0] m3;

  always_comb begin
    if (veca == REQ_INV) begin
      m3 = sa.zero_a ? '0 : xa;
    end else begin
      m3 = sa.fs ? -xa : xa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r   <= veca;
      p3_r   <= PW'(m3) * PW'(GAIN_S);
      sy3_r  <= sa.fs ? -yav : yav;
      ang3_r <= sa.zero_a ? '0 : sa.off_a + zav;
      sa3_r  <= sa;
    end
  end

  // ---------------- stage 4: round, set up second pass ----------------
  logic                 v4_r, t4_r;
  logic signed [CW-1:0] x4_r, y4_r;
  logic signed [ZW-1:0] z4_r;
  sbb_t                 sbb4_r;

  logic signed [PW-1:0] p3_rnd;
  logic signed [CW-1:0] r4, rr4, xg4, a4, b4;
  logic signed [ZW-1:0] off4, ang4;
  logic                 zb4;

  always_comb begin
    p3_rnd = (p3_r + (PW'(1) <<< 25)) >>> 26;
    r4     = CW'(p3_rnd);
    rr4    = sa3_r.y_neg ? -r4 : r4;
    ang4   = sa3_r.y_neg ? ang3_r - DEG180 : ang3_r;
    xg4    = CW'(sa3_r.x_in) <<< GUARD;
    zb4    = (sa3_r.x_in == '0) && (rr4 == '0);
    if (sa3_r.x_in[31]) begin
      a4   = -xg4;
      b4   = -rr4;
      off4 = rr4[CW-1] ? -DEG180 : DEG180;
    end else begin
      a4   = xg4;
      b4   = rr4;
      off4 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_r          <= t3_r;
      x4_r          <= (t3_r == REQ_INV) ? a4 : r4;
      y4_r          <= (t3_r == REQ_INV) ? b4 : '0;
      z4_r          <= (t3_r == REQ_INV) ? '0 : sa3_r.d_ang;
      sbb4_r.sy     <= sy3_r;
      sbb4_r.fd     <= sa3_r.fd;
      sbb4_r.ang_a  <= ang4;
      sbb4_r.zero_b <= zb4;
      sbb4_r.off_b  <= off4;
      sbb4_r.nz     <= sa3_r.nz;
    end
  end

  // ---------------- second CORDIC pass ----------------
  logic                 vb, vecb;
  logic signed [CW-1:0] xb, ybv;
  logic signed [ZW-1:0] zbv;
  logic [$bits(sbb_t)-1:0] sbb_bits;
  sbb_t                 sb;

  svdc_cordic #(.STEPS(CORDIC_STEPS), .SB_W($bits(sbb_t))) u_cordic_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v4_r),
    .in_vec   (t4_r),
    .in_x     (x4_r),
    .in_y     (y4_r),
    .in_z     (z4_r),
    .in_sb    (sbb4_r),
    .out_valid(vb),
    .out_vec  (vecb),
    .out_x    (xb),
    .out_y    (ybv),
    .out_z    (zbv),
    .out_sb   (sbb_bits)
  );

  assign sb = sbb_t'(sbb_bits);

  // ---------------- stage 5: forward outputs, norm multiply, sweep ----------------
  logic                 v5_r, t5_r, nz5_r;
  logic signed [31:0]   xo5_r, yo5_r, zo5_r;
  logic signed [PW-1:0] p5_r;
  logic signed [ZW-1:0] sw5_r, dh5_r;
  logic signed [CW-1:0] m5;

  assign m5 = sb.zero_b ? '0 : xb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5_r  <= vecb;
      nz5_r <= sb.nz;
      xo5_r <= sat32(sb.sy);
      yo5_r <= sat32(sb.fd ? -xb : xb);
      zo5_r <= sat32(sb.fd ? -ybv : ybv);
      p5_r  <= PW'(m5) * PW'(GAIN_S);
      sw5_r <= DEG90 - (sb.zero_b ? '0 : sb.off_b + zbv);
      dh5_r <= sb.ang_a;
    end
  end

  // ---------------- stage 6: norm rounding, first snap half ----------------
  logic                 v6_r, t6_r, nz6_r;
  logic signed [31:0]   xo6_r, yo6_r, zo6_r;
  logic [31:0]          len6_r;
  logic signed [AW-1:0] sw6_r, dh6_r;
  logic signed [PW-1:0] p5_rnd;
  logic [31:0]          len6;

  always_comb begin
    p5_rnd = (p5_r + (PW'(1) <<< 29)) >>> 30;
    if (p5_rnd[PW-1]) begin
      len6 = '0;
    end else if (p5_rnd > PW'(64'sd4294967295)) begin
      len6 = '1;
    end else begin
      len6 = p5_rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6_r   <= t5_r;
      nz6_r  <= nz5_r;
      xo6_r  <= xo5_r;
      yo6_r  <= yo5_r;
      zo6_r  <= zo5_r;
      len6_r <= len6;
      sw6_r  <= snap_run(rshr8(sw5_r), tol_r, 0, 4);
      dh6_r  <= snap_run(rshr8(dh5_r), tol_r, 0, 4);
    end
  end

  // ---------------- stage 7: second snap half, output register ----------------
  logic                 v7_r;
  logic signed [31:0]   xo7_r, yo7_r, zo7_r;
  logic [31:0]          len7_r;
  logic signed [25:0]   sw7_r, dh7_r;
  logic signed [25:0]   sw7, dh7;
  logic                 inv6;

  always_comb begin
    sw7  = sat26(snap_run(sw6_r, tol_r, 5, 8));
    dh7  = sat26(snap_run(dh6_r, tol_r, 5, 8));
    inv6 = (t6_r == REQ_INV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xo7_r  <= inv6 ? '0 : xo6_r;
      yo7_r  <= inv6 ? '0 : yo6_r;
      zo7_r  <= inv6 ? '0 : zo6_r;
      len7_r <= inv6 ? len6_r : '0;
      // zero vector gives zero angles
      sw7_r  <= (inv6 && nz6_r) ? sw7 : '0;
      dh7_r  <= (inv6 && nz6_r) ? dh7 : '0;
    end
  end

  assign out_valid        = v7_r;
  assign out_x_out        = xo7_r;
  assign out_y_out        = yo7_r;
  assign out_z_out        = zo7_r;
  assign out_length_out   = len7_r;
  assign out_sweep_out    = sw7_r;
  assign out_dihedral_out = dh7_r;

endmodule

// ----- sv/svdc_checker.sv -----
// Port-level checks for sweep_dihedral_vector_converter, attached by bind.
// Depends only on the top level's ports.
// No package use.
module svdc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_x_out,
  input logic signed [31:0] out_y_out,
  input logic signed [31:0] out_z_out,
  input logic [31:0]        out_length_out,
  input logic signed [25:0] out_sweep_out,
  input logic signed [25:0] out_dihedral_out,
  input logic               cfg_ready
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_out) && $stable(out_y_out)
      && $stable(out_z_out) && $stable(out_length_out) && $stable(out_sweep_out)
      && $stable(out_dihedral_out))
    else $error("result changed while stalled");

  // input side stalls exactly when the output register is blocked
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // a result is either forward or inverse, never both
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_x_out != 0 || out_y_out != 0 || out_z_out != 0)
      |-> out_length_out == 0 && out_sweep_out == 0 && out_dihedral_out == 0)
    else $error("forward and inverse fields both set");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind sweep_dihedral_vector_converter svdc_checker u_svdc_checker (.*);
